FILE: hw/rtl/patrig_pkg.sv
package patrig_pkg;

  // Field and state widths
  localparam int CLOSE_W   = 7;
  localparam int DELAY_W   = 13;
  localparam int PULSE_W   = 5;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 3;

  // Close time scale: percent
  localparam int PctFull   = 100;

  // Parameter defaults
  localparam int FULL_DELAY_TICKS_DEF = 7500;
  localparam int PULSE_TICKS_DEF      = 20;

  // Register word indexes
  localparam logic REG_CLOSE_TIME = 1'b0;

  typedef struct packed {
    logic pulse_active;
    logic armed;
  } core_sts_t;

endpackage

FILE: hw/rtl/patrig_core.sv
module patrig_core #(
  parameter int FULL_DELAY_TICKS = patrig_pkg::FULL_DELAY_TICKS_DEF,
  parameter int PULSE_TICKS      = patrig_pkg::PULSE_TICKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             step_en,
  input  logic                             level,
  input  logic [patrig_pkg::CLOSE_W-1:0]   close_time,
  output logic                             drive,
  output patrig_pkg::core_sts_t            sts
);

  localparam int CloseDepth = 1 << patrig_pkg::CLOSE_W;
  localparam logic [patrig_pkg::PULSE_W-1:0] PulseLoad = patrig_pkg::PULSE_W'(PULSE_TICKS);
  localparam logic [patrig_pkg::CLOSE_W-1:0] CloseNever = patrig_pkg::CLOSE_W'(patrig_pkg::PctFull);

  logic [patrig_pkg::DELAY_W-1:0] delay_tab [CloseDepth];

  // Delay per close time, settled at elaboration
  for (genvar i = 0; i < CloseDepth; i++) begin : g_tab
    localparam logic [patrig_pkg::DELAY_W-1:0] Dly =
      patrig_pkg::DELAY_W'((i * FULL_DELAY_TICKS) / patrig_pkg::PctFull);
    assign delay_tab[i] = Dly;
  end

  logic                           last_level_r,  last_level_nxt;
  logic [patrig_pkg::DELAY_W-1:0] delay_left_r,  delay_left_nxt;
  logic                           delay_armed_r, delay_armed_nxt;
  logic [patrig_pkg::PULSE_W-1:0] pulse_left_r,  pulse_left_nxt;
  logic                           drive_level_r, drive_level_nxt;

  logic                           armed_now;
  logic [patrig_pkg::DELAY_W-1:0] dec;
  logic [patrig_pkg::PULSE_W-1:0] pulse_mid;

  always_comb begin
    last_level_nxt  = last_level_r;
    delay_left_nxt  = delay_left_r;
    delay_armed_nxt = delay_armed_r;
    drive_level_nxt = drive_level_r;
    pulse_mid       = pulse_left_r;
    armed_now       = 1'b0;
    dec             = delay_left_r - patrig_pkg::DELAY_W'(delay_left_r != '0);

    if (pulse_left_r == '0) begin
      if (level != last_level_r) begin
        last_level_nxt = level;
        if (level) begin
          if (close_time == '0) begin
            drive_level_nxt = 1'b0;
          end else if (close_time < CloseNever) begin
            delay_left_nxt  = delay_tab[close_time];
            delay_armed_nxt = 1'b1;
            armed_now       = 1'b1;
          end
        end else begin
          drive_level_nxt = 1'b1;
        end
      end

      // countdown; a delay armed this tick waits until the next
      if (delay_armed_r && !armed_now) begin
        if (dec == '0) begin
          delay_armed_nxt = 1'b0;
          delay_left_nxt  = '0;
          drive_level_nxt = 1'b1;
          pulse_mid       = PulseLoad;
        end else begin
          delay_left_nxt = dec;
        end
      end
    end

    if (pulse_mid != '0) begin
      drive          = 1'b0;
      pulse_left_nxt = pulse_mid - 1'b1;
    end else begin
      drive          = drive_level_nxt;
      pulse_left_nxt = pulse_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= 1'b1;
      delay_left_r  <= '0;
      delay_armed_r <= 1'b0;
      pulse_left_r  <= '0;
      drive_level_r <= 1'b1;
    end else if (step_en) begin
      last_level_r  <= last_level_nxt;
      delay_left_r  <= delay_left_nxt;
      delay_armed_r <= delay_armed_nxt;
      pulse_left_r  <= pulse_left_nxt;
      drive_level_r <= drive_level_nxt;
    end
  end

  assign sts.pulse_active = (pulse_left_r != '0);
  assign sts.armed        = delay_armed_r;

endmodule

FILE: hw/rtl/phase_angle_scr_trigger.sv
// An accepted input transaction is registered in stage 1, then its result in the output register, shown on out_valid.
// Throughput: one transaction per cycle while out_stall is low; a sample can be taken while a result waits.
// The rate is set by the state update between the stage-1 and result registers.
// Reset (rst_n low, synchronous): pipeline empty, close_time 0, core drive level released,
// no delay armed, no pulse, last detector level taken as high.
module phase_angle_scr_trigger #(
  parameter int FULL_DELAY_TICKS = patrig_pkg::FULL_DELAY_TICKS_DEF,
  parameter int PULSE_TICKS      = patrig_pkg::PULSE_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_zero_level,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_scr_drive,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [patrig_pkg::CFG_AW-1:0]   paddr,
  input  logic [patrig_pkg::CFG_DW-1:0]   pwdata,
  output logic [patrig_pkg::CFG_DW-1:0]   prdata,
  output logic                            pready
);

  logic [patrig_pkg::CLOSE_W-1:0] close_time_r;
  logic                           s1_valid_r;
  logic                           s1_level_r;
  logic                           out_valid_r;
  logic                           out_drive_r;
  logic                           out_free;
  logic                           in_fire;
  logic                           s1_fire;
  logic                           core_drive;
  logic                           cfg_wr;
  logic                           cfg_hit;
  patrig_pkg::core_sts_t          core_sts;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == patrig_pkg::REG_CLOSE_TIME);
  assign cfg_wr  = psel && penable && pwrite && cfg_hit;
  assign prdata  = cfg_hit ? patrig_pkg::CFG_DW'(close_time_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_time_r <= '0;
    end else if (cfg_wr) begin
      close_time_r <= pwdata[patrig_pkg::CLOSE_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level_r <= in_zero_level;
    end
  end

  patrig_core #(
    .FULL_DELAY_TICKS (FULL_DELAY_TICKS),
    .PULSE_TICKS      (PULSE_TICKS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_fire),
    .level      (s1_level_r),
    .close_time (close_time_r),
    .drive      (core_drive),
    .sts        (core_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_drive_r <= core_drive;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scr_drive = out_drive_r;

`ifndef SYNTHESIS
  a_pulse_drives_low: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && core_sts.pulse_active |=> !out_scr_drive)
    else $error("drive released during pulse");

  a_armed_not_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    !(core_sts.armed && core_sts.pulse_active))
    else $error("delay armed while pulse runs");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free pipeline");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid)
    else $error("processed transaction gave no result");
`endif

endmodule
